// ===== hdl/pdmd_pkg.sv =====
`timescale 1ns / 1ps

package pdmd_pkg;

    // Largest message the decoder accepts by default.
    localparam int unsigned MAX_MSG_BYTES_DEF = 256;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_VALID     = 2'd0;
    localparam status_t STATUS_MALFORMED = 2'd1;
    localparam status_t STATUS_NO_PORT   = 2'd2;

    typedef struct packed {
        logic [31:0] port_number;
        logic [7:0]  payload_offset;
        logic [7:0]  payload_length;
        logic        resp_wanted;
        logic [31:0] dest_id;
        logic [31:0] source_id;
        logic [31:0] query_id;
        logic [31:0] answer_id;
        logic [31:0] emoji_code;
        logic        bitfield_seen;
        logic [31:0] bitfield_value;
        status_t     status;
    } result_t;

endpackage

// ===== hdl/pdmd_channels.sv =====
`timescale 1ns / 1ps

interface pdmd_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface pdmd_result_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          port_number;
    logic [7:0]           payload_offset;
    logic [7:0]           payload_length;
    logic                 resp_wanted;
    logic [31:0]          dest_id;
    logic [31:0]          source_id;
    logic [31:0]          query_id;
    logic [31:0]          answer_id;
    logic [31:0]          emoji_code;
    logic                 bitfield_seen;
    logic [31:0]          bitfield_value;
    pdmd_pkg::status_t    status;

    modport source (
        output valid, output port_number, output payload_offset, output payload_length,
        output resp_wanted, output dest_id, output source_id, output query_id,
        output answer_id, output emoji_code, output bitfield_seen, output bitfield_value,
        output status, input ready
    );
    modport sink (
        input valid, input port_number, input payload_offset, input payload_length,
        input resp_wanted, input dest_id, input source_id, input query_id,
        input answer_id, input emoji_code, input bitfield_seen, input bitfield_value,
        input status, output ready
    );
endinterface

// ===== hdl/pdmd_parse.sv =====
`timescale 1ns / 1ps

module pdmd_parse #(
    parameter int unsigned MAX_MSG_BYTES = pdmd_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [7:0]         data_byte,
    input  logic               end_of_message,
    output logic               done,
    output pdmd_pkg::result_t  result
);

    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1);

    localparam logic [2:0]  WT_VARINT  = 3'd0;
    localparam logic [2:0]  WT_FIXED64 = 3'd1;
    localparam logic [2:0]  WT_LEN     = 3'd2;
    localparam logic [2:0]  WT_FIXED32 = 3'd5;

    localparam logic [31:0] FIELD_PORT    = 32'd1;
    localparam logic [31:0] FIELD_PAYLOAD = 32'd2;
    localparam logic [31:0] FIELD_WANT    = 32'd3;
    localparam logic [31:0] FIELD_ID_LO   = 32'd4;
    localparam logic [31:0] FIELD_ID_HI   = 32'd8;
    localparam logic [31:0] FIELD_BITS    = 32'd9;

    localparam logic [3:0]  LAST_VARINT_BYTE = 4'd9;
    localparam int          NUM_IDS          = 5;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARINT,
        PH_FIXED,
        PH_LEN,
        PH_PAYLOAD
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [63:0]        acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [31:0]        field_reg, field_next;
    logic [2:0]         wt_reg, wt_next;
    logic [POS_W-1:0]   remain_reg, remain_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               err_reg, err_next;
    logic               port_seen_reg, port_seen_next;
    logic [31:0]        port_reg, port_next;
    logic [7:0]         off_reg, off_next;
    logic [7:0]         len_reg, len_next;
    logic               want_reg, want_next;
    logic [31:0]        id_reg [NUM_IDS];
    logic [31:0]        id_next [NUM_IDS];
    logic               has_bits_reg, has_bits_next;
    logic [31:0]        bits_reg, bits_next;

    logic [63:0]        var_acc;
    logic [63:0]        fix_acc;
    logic [3:0]         cnt_inc;
    logic [3:0]         fixed_need;
    logic [POS_W-1:0]   pos_plus1;
    logic [POS_W-1:0]   room;
    logic [2:0]         id_idx;
    logic               more;
    pdmd_pkg::status_t  status;

    assign more       = data_byte[7];
    assign var_acc    = acc_reg | (64'(data_byte[6:0]) << (7'(cnt_reg) * 7'd7));
    assign fix_acc    = acc_reg | (64'(data_byte) << {cnt_reg[2:0], 3'b000});
    assign cnt_inc    = cnt_reg + 4'd1;
    assign fixed_need = (wt_reg == WT_FIXED64) ? 4'd8 : 4'd4;
    assign pos_plus1  = pos_reg + 1'b1;
    assign room       = POS_W'(MAX_MSG_BYTES) - pos_plus1;
    // Fields 4 to 8 land at slots 0 to 4; the subtraction wraps field 8 to slot 4.
    assign id_idx     = field_reg[2:0] - 3'd4;

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        field_next     = field_reg;
        wt_next        = wt_reg;
        remain_next    = remain_reg;
        err_next       = err_reg;
        port_seen_next = port_seen_reg;
        port_next      = port_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        want_next      = want_reg;
        id_next        = id_reg;
        has_bits_next  = has_bits_reg;
        bits_next      = bits_reg;
        pos_next       = (pos_reg < POS_W'(MAX_MSG_BYTES)) ? pos_plus1 : pos_reg;

        if (!err_reg)
        begin
            if (pos_reg >= POS_W'(MAX_MSG_BYTES))
            begin
                err_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_TAG, PH_VARINT, PH_LEN:
                    begin
                        if (more)
                        begin
                            acc_next = var_acc;
                            if (cnt_reg >= LAST_VARINT_BYTE)
                                err_next = 1'b1;
                            else
                                cnt_next = cnt_inc;
                        end
                        else if (phase_reg == PH_TAG)
                        begin
                            acc_next = var_acc;
                            if (var_acc[63:3] == 61'd0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                field_next = var_acc[34:3];
                                wt_next    = var_acc[2:0];
                                acc_next   = 64'd0;
                                cnt_next   = 4'd0;
                                case (var_acc[2:0])
                                    WT_VARINT:  phase_next = PH_VARINT;
                                    WT_FIXED64: phase_next = PH_FIXED;
                                    WT_LEN:     phase_next = PH_LEN;
                                    WT_FIXED32: phase_next = PH_FIXED;
                                    default:    err_next   = 1'b1;
                                endcase
                            end
                        end
                        else if (phase_reg == PH_VARINT)
                        begin
                            if (field_reg == FIELD_PORT)
                            begin
                                port_next      = var_acc[31:0];
                                port_seen_next = 1'b1;
                            end
                            else if (field_reg == FIELD_WANT)
                            begin
                                want_next = (var_acc != 64'd0);
                            end
                            else if (field_reg == FIELD_BITS)
                            begin
                                has_bits_next = 1'b1;
                                bits_next     = var_acc[31:0];
                            end
                            acc_next   = 64'd0;
                            cnt_next   = 4'd0;
                            phase_next = PH_TAG;
                        end
                        else
                        begin
                            // Length prefix: it must fit in what is left of the message.
                            if (var_acc > 64'(room))
                            begin
                                acc_next = var_acc;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                if (field_reg == FIELD_PAYLOAD)
                                begin
                                    off_next = 8'(pos_plus1);
                                    len_next = var_acc[7:0];
                                end
                                remain_next = POS_W'(var_acc);
                                phase_next  = (var_acc == 64'd0) ? PH_TAG : PH_PAYLOAD;
                                acc_next    = 64'd0;
                                cnt_next    = 4'd0;
                            end
                        end
                    end
                    PH_FIXED:
                    begin
                        acc_next = fix_acc;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= fixed_need)
                        begin
                            if (wt_reg == WT_FIXED32 && field_reg >= FIELD_ID_LO
                                && field_reg <= FIELD_ID_HI)
                                id_next[id_idx] = fix_acc[31:0];
                            acc_next   = 64'd0;
                            cnt_next   = 4'd0;
                            phase_next = PH_TAG;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (remain_reg != '0)
                            remain_next = remain_reg - 1'b1;
                        if (remain_next == '0)
                            phase_next = PH_TAG;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (err_next || phase_next != PH_TAG || cnt_next != 4'd0)
            status = pdmd_pkg::STATUS_MALFORMED;
        else if (!port_seen_next || port_next == 32'd0)
            status = pdmd_pkg::STATUS_NO_PORT;
        else
            status = pdmd_pkg::STATUS_VALID;

        result = '0;
        if (status != pdmd_pkg::STATUS_MALFORMED)
        begin
            result.port_number    = port_next;
            result.payload_offset = off_next;
            result.payload_length = len_next;
            result.resp_wanted    = want_next;
            result.dest_id        = id_next[0];
            result.source_id      = id_next[1];
            result.query_id       = id_next[2];
            result.answer_id      = id_next[3];
            result.emoji_code     = id_next[4];
            result.bitfield_seen  = has_bits_next;
            result.bitfield_value = bits_next;
        end
        result.status = status;
    end

    assign done = in_fire && end_of_message;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            acc_reg       <= 64'd0;
            cnt_reg       <= 4'd0;
            field_reg     <= 32'd0;
            wt_reg        <= 3'd0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            err_reg       <= 1'b0;
            port_seen_reg <= 1'b0;
            port_reg      <= 32'd0;
            off_reg       <= 8'd0;
            len_reg       <= 8'd0;
            want_reg      <= 1'b0;
            for (int i = 0; i < NUM_IDS; i++)
                id_reg[i] <= 32'd0;
            has_bits_reg  <= 1'b0;
            bits_reg      <= 32'd0;
        end
        else if (done)
        begin
            // The final byte of a message returns the parser to its reset state.
            phase_reg     <= PH_TAG;
            acc_reg       <= 64'd0;
            cnt_reg       <= 4'd0;
            field_reg     <= 32'd0;
            wt_reg        <= 3'd0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            err_reg       <= 1'b0;
            port_seen_reg <= 1'b0;
            port_reg      <= 32'd0;
            off_reg       <= 8'd0;
            len_reg       <= 8'd0;
            want_reg      <= 1'b0;
            for (int i = 0; i < NUM_IDS; i++)
                id_reg[i] <= 32'd0;
            has_bits_reg  <= 1'b0;
            bits_reg      <= 32'd0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            field_reg     <= field_next;
            wt_reg        <= wt_next;
            remain_reg    <= remain_next;
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            port_seen_reg <= port_seen_next;
            port_reg      <= port_next;
            off_reg       <= off_next;
            len_reg       <= len_next;
            want_reg      <= want_next;
            id_reg        <= id_next;
            has_bits_reg  <= has_bits_next;
            bits_reg      <= bits_next;
        end
    end

endmodule

// ===== hdl/pdmd_out.sv =====
`timescale 1ns / 1ps

module pdmd_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pdmd_pkg::result_t  load_data,
    input  logic               out_ready,
    output logic               out_valid,
    output pdmd_pkg::result_t  out_data
);

    logic               valid_reg;
    pdmd_pkg::result_t  data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/protobuf_data_message_decoder_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Request contents
// msg       in         data_byte, end_of_message (one message byte)
// result    out        decoded fields and status, one per message
//
// Each byte is parsed in the cycle it is accepted; one per cycle unless stalled.
// The result of a message is registered and appears the cycle after its final byte.
// A waiting result that is not taken stalls the input: msg.ready is low while the
// result register is full and result.ready is low.
// Reset clears the parse state and empties the result register.

module protobuf_data_message_decoder_top #(
    parameter int unsigned MAX_MSG_BYTES = pdmd_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pdmd_msg_if.sink       msg,
    pdmd_result_if.source  result
);

    logic               in_fire;
    logic               done;
    logic               out_valid;
    pdmd_pkg::result_t  parsed;
    pdmd_pkg::result_t  held;

    assign msg.ready = !out_valid || result.ready;
    assign in_fire   = msg.valid && msg.ready;

    pdmd_parse #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .data_byte      (msg.data_byte),
        .end_of_message (msg.end_of_message),
        .done           (done),
        .result         (parsed)
    );

    pdmd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (done),
        .load_data (parsed),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .out_data  (held)
    );

    assign result.valid          = out_valid;
    assign result.port_number    = held.port_number;
    assign result.payload_offset = held.payload_offset;
    assign result.payload_length = held.payload_length;
    assign result.resp_wanted    = held.resp_wanted;
    assign result.dest_id        = held.dest_id;
    assign result.source_id      = held.source_id;
    assign result.query_id       = held.query_id;
    assign result.answer_id      = held.answer_id;
    assign result.emoji_code     = held.emoji_code;
    assign result.bitfield_seen  = held.bitfield_seen;
    assign result.bitfield_value = held.bitfield_value;
    assign result.status         = held.status;

endmodule

// ===== hdl/pdmd_checker.sv =====
`timescale 1ns / 1ps

module pdmd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [31:0]        port_number,
    input  logic [7:0]         payload_offset,
    input  logic [7:0]         payload_length,
    input  logic               resp_wanted,
    input  logic [31:0]        dest_id,
    input  logic [31:0]        source_id,
    input  logic [31:0]        query_id,
    input  logic [31:0]        answer_id,
    input  logic [31:0]        emoji_code,
    input  logic               bitfield_seen,
    input  logic [31:0]        bitfield_value,
    input  pdmd_pkg::status_t  status
);

    // A held result keeps its contents until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(port_number))
        else $error("result changed while stalled");

    // A new result only follows an accepted byte.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted byte");

    // A full, stalled result register blocks the input.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result register is blocked");

    // Malformed messages report nothing but the status.
    a_malformed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pdmd_pkg::STATUS_MALFORMED |->
            port_number == 32'd0 && payload_offset == 8'd0 && payload_length == 8'd0
            && !resp_wanted && dest_id == 32'd0 && source_id == 32'd0
            && query_id == 32'd0 && answer_id == 32'd0 && emoji_code == 32'd0
            && !bitfield_seen && bitfield_value == 32'd0)
        else $error("malformed result carries data");

    // A well-formed message is valid exactly when it has a nonzero port.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pdmd_pkg::STATUS_MALFORMED |->
            (status == pdmd_pkg::STATUS_VALID || status == pdmd_pkg::STATUS_NO_PORT)
            && ((status == pdmd_pkg::STATUS_VALID) == (port_number != 32'd0))
            && (bitfield_seen || bitfield_value == 32'd0))
        else $error("status inconsistent with decoded fields");

endmodule

bind protobuf_data_message_decoder_top pdmd_checker u_pdmd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (msg.valid),
    .in_ready       (msg.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .port_number    (result.port_number),
    .payload_offset (result.payload_offset),
    .payload_length (result.payload_length),
    .resp_wanted    (result.resp_wanted),
    .dest_id        (result.dest_id),
    .source_id      (result.source_id),
    .query_id       (result.query_id),
    .answer_id      (result.answer_id),
    .emoji_code     (result.emoji_code),
    .bitfield_seen  (result.bitfield_seen),
    .bitfield_value (result.bitfield_value),
    .status         (result.status)
);
